FILE: rtl/fdkr_pkg.sv
// Shared types, constants and helpers for the key/value queue with duplicate-key reject.
// No dependencies. Compiled first.
`default_nettype none

package fdkr_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int IDX_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_W        = 32;
    localparam int ACTION_W      = 2;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 5;

    localparam int CQ_DEPTH = 2;
    localparam int CQ_IDX_W = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    localparam logic [ACTION_W-1:0] ACT_ENQUEUE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DEQUEUE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PEEK    = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_ENQ,
        OP_DEQ,
        OP_PEEK,
        OP_NOP
    } op_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_READ
    } back_state_t;

    typedef struct packed {
        op_t                       op;
        logic signed [DATA_W-1:0]  key;
        logic signed [DATA_W-1:0]  value;
    } cmd_t;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        if (i == IDX_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = i + 1'b1;
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        if (i == '0)
            r = IDX_W'(QUEUE_DEPTH - 1);
        else
            r = i - 1'b1;
        return r;
    endfunction

    function automatic logic [CQ_IDX_W-1:0] cq_inc(input logic [CQ_IDX_W-1:0] i);
        logic [CQ_IDX_W-1:0] r;
        if (i == CQ_IDX_W'(CQ_DEPTH - 1))
            r = '0;
        else
            r = i + 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/fdkr_if.sv
// Request and response channel interfaces (valid/ready plus payload).
// Depends on fdkr_pkg.
`default_nettype none

interface fdkr_req_if
    import fdkr_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [ACTION_W-1:0]       action;
    logic signed [DATA_W-1:0]  entry_key;
    logic signed [DATA_W-1:0]  entry_value;

    modport source (output valid, action, entry_key, entry_value, input ready);
    modport sink   (input valid, action, entry_key, entry_value, output ready);
endinterface

interface fdkr_rsp_if
    import fdkr_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic [STATUS_W-1:0]           status;
    logic signed [DATA_W-1:0]      result_key;
    logic signed [DATA_W-1:0]      result_value;
    logic [ENTRY_COUNT_W-1:0]      entry_count;
    logic                          queue_empty;

    modport source (output valid, status, result_key, result_value, entry_count,
                    queue_empty, input ready);
    modport sink   (input valid, status, result_key, result_value, entry_count,
                    queue_empty, output ready);
endinterface

`default_nettype wire

FILE: rtl/fdkr_front.sv
// Front end: accepts request transactions, decodes the action into a command.
// Depends on fdkr_pkg and fdkr_req_if.
`default_nettype none

module fdkr_front
    import fdkr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    fdkr_req_if.sink   request,
    output logic       push_valid,
    input  wire logic  push_ready,
    output cmd_t       push_cmd
);

    logic hold_valid_reg;
    logic hold_valid_next;
    cmd_t cmd_reg;
    op_t  op_dec;
    logic take;

    always_comb
    begin
        case (request.action)
            ACT_ENQUEUE: op_dec = OP_ENQ;
            ACT_DEQUEUE: op_dec = OP_DEQ;
            ACT_PEEK:    op_dec = OP_PEEK;
            default:     op_dec = OP_NOP;
        endcase
    end

    assign request.ready = !hold_valid_reg || push_ready;
    assign take          = request.valid && request.ready;
    assign push_valid    = hold_valid_reg;
    assign push_cmd      = cmd_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (take)
            hold_valid_next = 1'b1;
        else if (push_ready)
            hold_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else
            hold_valid_reg <= hold_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg.op    <= op_dec;
            cmd_reg.key   <= request.entry_key;
            cmd_reg.value <= request.entry_value;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fdkr_cmd_queue.sv
// Short command queue between front and back end.
// Depends on fdkr_pkg.
`default_nettype none

module fdkr_cmd_queue
    import fdkr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push_valid,
    output logic       push_ready,
    input  wire cmd_t  push_cmd,
    output logic       pop_valid,
    input  wire logic  pop_ready,
    output cmd_t       pop_cmd
);

    cmd_t                 slots [CQ_DEPTH];
    logic [CQ_IDX_W-1:0]  wr_ptr_reg;
    logic [CQ_IDX_W-1:0]  wr_ptr_next;
    logic [CQ_IDX_W-1:0]  rd_ptr_reg;
    logic [CQ_IDX_W-1:0]  rd_ptr_next;
    logic [CQ_CNT_W-1:0]  used_reg;
    logic [CQ_CNT_W-1:0]  used_next;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (used_reg != CQ_CNT_W'(CQ_DEPTH));
    assign pop_valid  = (used_reg != '0);
    assign pop_cmd    = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? cq_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? cq_inc(rd_ptr_reg) : rd_ptr_reg;
        used_next   = used_reg;
        if (do_push && !do_pop)
            used_next = used_reg + 1'b1;
        else if (do_pop && !do_push)
            used_next = used_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            used_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            used_reg   <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

FILE: rtl/fdkr_back.sv
// Back end: key/value store, head/tail/fill state, duplicate scan and result register.
// Depends on fdkr_pkg and fdkr_rsp_if.
`default_nettype none

module fdkr_back
    import fdkr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cmd_valid,
    output logic       cmd_ready,
    input  wire cmd_t  cmd_in,
    fdkr_rsp_if.source response
);

    logic [DATA_W-1:0] key_mem   [QUEUE_DEPTH];
    logic [DATA_W-1:0] value_mem [QUEUE_DEPTH];

    back_state_t       state_reg;
    back_state_t       state_next;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic [IDX_W-1:0]  head_reg;
    logic [IDX_W-1:0]  head_next;
    logic [IDX_W-1:0]  tail_reg;
    logic [IDX_W-1:0]  tail_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [IDX_W-1:0]  scan_ptr_reg;
    logic [IDX_W-1:0]  scan_ptr_next;
    logic [CNT_W-1:0]  issue_cnt_reg;
    logic [CNT_W-1:0]  issue_cnt_next;
    logic              pend_reg;
    logic              pend_next;
    logic [DATA_W-1:0] rd_key_reg;
    logic [DATA_W-1:0] rd_value_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;

    logic              out_valid_reg;
    logic              out_valid_next;
    status_t           out_status_reg;
    status_t           out_status_next;
    logic [DATA_W-1:0] out_key_reg;
    logic [DATA_W-1:0] out_key_next;
    logic [DATA_W-1:0] out_value_reg;
    logic [DATA_W-1:0] out_value_next;
    logic [CNT_W-1:0]  out_count_reg;
    logic [CNT_W-1:0]  out_count_next;
    logic              out_load;

    logic              out_free;
    logic              pop;
    logic              match;
    logic              scan_done;
    logic              full;

    assign out_free  = !out_valid_reg || response.ready;
    assign pop       = (state_reg == B_IDLE) && cmd_valid && out_free;
    assign cmd_ready = pop;
    assign match     = pend_reg && (rd_key_reg == cmd_reg.key);
    assign scan_done = (state_reg == B_SCAN) && (match || (issue_cnt_reg == count_reg));
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    case (cmd_in.op)
                        OP_ENQ:  state_next = B_SCAN;
                        OP_DEQ,
                        OP_PEEK: state_next = (count_reg != '0) ? B_READ : B_IDLE;
                        default: state_next = B_IDLE;
                    endcase
                end
            end
            B_SCAN:
            begin
                if (scan_done)
                    state_next = B_IDLE;
            end
            B_READ:  state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd_next        = cmd_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        scan_ptr_next   = scan_ptr_reg;
        issue_cnt_next  = issue_cnt_reg;
        pend_next       = 1'b0;
        rd_addr         = scan_ptr_reg;
        wr_en           = 1'b0;
        out_load        = 1'b0;
        out_status_next = ST_OK;
        out_key_next    = '0;
        out_value_next  = '0;
        out_count_next  = count_reg;

        case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    cmd_next       = cmd_in;
                    scan_ptr_next  = head_reg;
                    issue_cnt_next = '0;
                    case (cmd_in.op)
                        OP_DEQ:
                        begin
                            rd_addr = head_reg;
                            if (count_reg == '0)
                            begin
                                out_load        = 1'b1;
                                out_status_next = ST_EMPTY;
                            end
                        end
                        OP_PEEK:
                        begin
                            rd_addr = idx_dec(tail_reg);
                            if (count_reg == '0)
                            begin
                                out_load        = 1'b1;
                                out_status_next = ST_EMPTY;
                            end
                        end
                        OP_NOP:
                        begin
                            out_load = 1'b1;
                        end
                        default:
                        begin
                            rd_addr = head_reg;
                        end
                    endcase
                end
            end
            B_SCAN:
            begin
                if (!scan_done)
                begin
                    // one read issued per cycle, compared the cycle after
                    rd_addr        = scan_ptr_reg;
                    scan_ptr_next  = idx_inc(scan_ptr_reg);
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                    pend_next      = 1'b1;
                end
                else
                begin
                    out_load = 1'b1;
                    if (match)
                        out_status_next = ST_DUP;
                    else if (full)
                        out_status_next = ST_FULL;
                    else
                    begin
                        wr_en          = 1'b1;
                        tail_next      = idx_inc(tail_reg);
                        count_next     = count_reg + 1'b1;
                        out_count_next = count_reg + 1'b1;
                    end
                end
            end
            B_READ:
            begin
                out_load       = 1'b1;
                out_key_next   = rd_key_reg;
                out_value_next = rd_value_reg;
                if (cmd_reg.op == OP_DEQ)
                begin
                    head_next      = idx_inc(head_reg);
                    count_next     = count_reg - 1'b1;
                    out_count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (response.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            scan_ptr_reg  <= '0;
            issue_cnt_reg <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            scan_ptr_reg  <= scan_ptr_next;
            issue_cnt_reg <= issue_cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_key_reg    <= out_key_next;
            out_value_reg  <= out_value_next;
            out_count_reg  <= out_count_next;
        end
    end

    // key/value memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[tail_reg]   <= cmd_reg.key;
            value_mem[tail_reg] <= cmd_reg.value;
        end
        rd_key_reg   <= key_mem[rd_addr];
        rd_value_reg <= value_mem[rd_addr];
    end

    assign response.valid        = out_valid_reg;
    assign response.status       = out_status_reg;
    assign response.result_key   = out_key_reg;
    assign response.result_value = out_value_reg;
    assign response.entry_count  = ENTRY_COUNT_W'(out_count_reg);
    assign response.queue_empty  = (out_count_reg == '0);

endmodule

`default_nettype wire

FILE: rtl/fifo_with_duplicate_key_reject.sv
// Top level: key/value FIFO that rejects enqueue of a key already held.
// Depends on fdkr_pkg, fdkr_if, fdkr_front, fdkr_cmd_queue, fdkr_back.
//
//   channel    dir   handshake       payload
//   request    in    valid/ready     action, entry_key, entry_value
//   response   out   valid/ready     status, result_key, result_value,
//                                    entry_count, queue_empty
//
// Enqueue: the back end scans the N entries held, one key read and compare per cycle
// through the single read port; a matching key ends the scan early.
// Dequeue and peek pass through B_READ; empty queue and unused action answer from B_IDLE.
// Front register and a 2-deep command queue keep accepting while a result waits.
// Async active-low reset empties the queue; memory contents are not cleared.
`default_nettype none

module fifo_with_duplicate_key_reject
    import fdkr_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    fdkr_req_if.sink    request,
    fdkr_rsp_if.source  response
);

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    fdkr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    fdkr_cmd_queue u_cmd_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    fdkr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd_in    (pop_cmd),
        .response  (response)
    );

endmodule

`default_nettype wire

FILE: verif/tb_fifo_with_duplicate_key_reject.sv
// Self-checking testbench for fifo_with_duplicate_key_reject: directed table, then random traffic.
// Responses are compared with typed table rows or a queue predictor; random stalls on both channels.
// Depends on rtl/fdkr_pkg.sv, rtl/fdkr_if.sv and the block's RTL.
`default_nettype none

module tb_fifo_with_duplicate_key_reject;
    timeunit 1ns;
    timeprecision 1ps;

    import fdkr_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic signed [DATA_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] KEY_MAX = 32'sh7fff_ffff;
    localparam int RANDOM_OPS  = 650;
    localparam int CALM_OPS    = 80;
    localparam int LONG_HOLD   = 320;
    localparam int DRAIN_WAIT  = 40;
    localparam int CYCLE_LIMIT = 200000;
    localparam int POOL_SIZE   = 24;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic signed [DATA_W-1:0]  key;
        logic signed [DATA_W-1:0]  value;
    } queue_op_t;

    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  rkey;
        logic signed [DATA_W-1:0]  rval;
        logic [ENTRY_COUNT_W-1:0]  count;
        logic                      empty;
    } queue_reply_t;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic signed [DATA_W-1:0]  key;
        logic signed [DATA_W-1:0]  value;
        int                        reps;
        bit                        typed;
        queue_reply_t              reply;
    } directed_row_t;

    directed_row_t directed_plan [13] = '{
        '{ACT_DEQUEUE, 32'sd0, 32'sd0, 1, 1'b1, '{ST_EMPTY, 32'sd0, 32'sd0, 5'd0, 1'b1}},
        '{ACT_PEEK,    32'sd0, 32'sd0, 1, 1'b1, '{ST_EMPTY, 32'sd0, 32'sd0, 5'd0, 1'b1}},
        '{ACT_UNUSED,  KEY_MAX, KEY_MIN, 1, 1'b1, '{ST_OK, 32'sd0, 32'sd0, 5'd0, 1'b1}},
        '{ACT_ENQUEUE, KEY_MIN, KEY_MAX, 1, 1'b1, '{ST_OK, 32'sd0, 32'sd0, 5'd1, 1'b0}},
        '{ACT_ENQUEUE, KEY_MIN, 32'sd0, 1, 1'b1, '{ST_DUP, 32'sd0, 32'sd0, 5'd1, 1'b0}},
        '{ACT_PEEK,    32'sd0, 32'sd0, 1, 1'b0, '{ST_OK, 32'sd0, 32'sd0, 5'd0, 1'b0}},
        '{ACT_ENQUEUE, KEY_MAX, KEY_MIN, 1, 1'b1, '{ST_OK, 32'sd0, 32'sd0, 5'd2, 1'b0}},
        '{ACT_ENQUEUE, 32'sd0, -32'sd1, 14, 1'b0, '{ST_OK, 32'sd0, 32'sd0, 5'd0, 1'b0}},
        '{ACT_ENQUEUE, 32'sh100, -32'sd1, 1, 1'b1, '{ST_FULL, 32'sd0, 32'sd0, 5'd16, 1'b0}},
        '{ACT_ENQUEUE, KEY_MAX, 32'sd5, 1, 1'b1, '{ST_DUP, 32'sd0, 32'sd0, 5'd16, 1'b0}},
        '{ACT_PEEK,    32'sd0, 32'sd0, 1, 1'b0, '{ST_OK, 32'sd0, 32'sd0, 5'd0, 1'b0}},
        '{ACT_DEQUEUE, 32'sd0, 32'sd0, 1, 1'b1, '{ST_OK, KEY_MIN, KEY_MAX, 5'd15, 1'b0}},
        '{ACT_DEQUEUE, 32'sd0, 32'sd0, 2, 1'b0, '{ST_OK, 32'sd0, 32'sd0, 5'd0, 1'b0}}
    };

    logic clk;
    logic rst_n;
    int   fail_count;
    int   cycle_count;
    bit   calm_tail;
    bit   long_hold_pending;

    fdkr_req_if req_bus();
    fdkr_rsp_if rsp_bus();

    fifo_with_duplicate_key_reject uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_bus),
        .response (rsp_bus)
    );

    logic signed [DATA_W-1:0] model_keys [QUEUE_DEPTH];
    logic signed [DATA_W-1:0] model_vals [QUEUE_DEPTH];
    int model_head;
    int model_tail;
    int model_fill;

    queue_reply_t expected_replies [$];
    queue_reply_t oldest_reply;
    logic signed [DATA_W-1:0] key_pool [POOL_SIZE];

    always #6 clk = ~clk;

    function automatic queue_reply_t queue_model_step(input queue_op_t op);
        queue_reply_t r;
        int slot;
        bit found;
        r.status = ST_OK;
        r.rkey   = '0;
        r.rval   = '0;
        found    = 1'b0;
        case (op.action)
            ACT_ENQUEUE:
            begin
                for (int n = 0; n < model_fill; n++)
                    if (model_keys[(model_head + n) % QUEUE_DEPTH] == op.key)
                        found = 1'b1;
                if (found)
                    r.status = ST_DUP;
                else if (model_fill >= QUEUE_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    model_keys[model_tail] = op.key;
                    model_vals[model_tail] = op.value;
                    model_tail = (model_tail + 1) % QUEUE_DEPTH;
                    model_fill++;
                end
            end
            ACT_DEQUEUE:
            begin
                if (model_fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.rkey = model_keys[model_head];
                    r.rval = model_vals[model_head];
                    model_head = (model_head + 1) % QUEUE_DEPTH;
                    model_fill--;
                end
            end
            ACT_PEEK:
            begin
                if (model_fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    slot   = (model_tail + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                    r.rkey = model_keys[slot];
                    r.rval = model_vals[slot];
                end
            end
            default:
            begin
            end
        endcase
        r.count = ENTRY_COUNT_W'(model_fill);
        r.empty = (model_fill == 0);
        return r;
    endfunction

    task automatic issue_op(input queue_op_t op, input bit typed, input queue_reply_t typed_reply);
        queue_reply_t predicted;
        if (!calm_tail && $urandom_range(0, 4) == 0)
        begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.action      <= op.action;
        req_bus.entry_key   <= op.key;
        req_bus.entry_value <= op.value;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        predicted = queue_model_step(op);
        expected_replies.push_back(typed ? typed_reply : predicted);
    endtask

    // response side: random stall bursts, plus long holds on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                rsp_bus.ready <= 1'b0;
                for (int h = 0; h < LONG_HOLD; h++)
                    @(posedge clk);
            end
            else if (!calm_tail && $urandom_range(0, 3) == 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    end

    // one check per accepted response transaction
    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (expected_replies.size() == 0)
            begin
                $error("response transaction with nothing pending");
                fail_count++;
            end
            else
            begin
                oldest_reply = expected_replies.pop_front();
                if (rsp_bus.status !== oldest_reply.status)
                begin
                    $error("status: expected %0d, actual %0d", oldest_reply.status,
                           rsp_bus.status);
                    fail_count++;
                end
                if (rsp_bus.result_key !== oldest_reply.rkey)
                begin
                    $error("result_key: expected %0d, actual %0d", oldest_reply.rkey,
                           rsp_bus.result_key);
                    fail_count++;
                end
                if (rsp_bus.result_value !== oldest_reply.rval)
                begin
                    $error("result_value: expected %0d, actual %0d", oldest_reply.rval,
                           rsp_bus.result_value);
                    fail_count++;
                end
                if (rsp_bus.entry_count !== oldest_reply.count)
                begin
                    $error("entry_count: expected %0d, actual %0d", oldest_reply.count,
                           rsp_bus.entry_count);
                    fail_count++;
                end
                if (rsp_bus.queue_empty !== oldest_reply.empty)
                begin
                    $error("queue_empty: expected %0d, actual %0d", oldest_reply.empty,
                           rsp_bus.queue_empty);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        queue_op_t    op;
        queue_reply_t no_reply;
        int           pick;
        bit           filling;

        clk                 = 1'b0;
        rst_n               = 1'b0;
        fail_count          = 0;
        cycle_count         = 0;
        calm_tail           = 1'b0;
        long_hold_pending   = 1'b0;
        req_bus.valid       = 1'b0;
        req_bus.action      = ACT_ENQUEUE;
        req_bus.entry_key   = '0;
        req_bus.entry_value = '0;
        rsp_bus.ready       = 1'b0;
        no_reply            = '0;
        model_head          = 0;
        model_tail          = 0;
        model_fill          = 0;

        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = '0;
        key_pool[3] = -32'sd1;
        for (int p = 4; p < POOL_SIZE; p++)
            key_pool[p] = $urandom;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[r])
        begin
            for (int i = 0; i < directed_plan[r].reps; i++)
            begin
                op.action = directed_plan[r].action;
                op.key    = directed_plan[r].key + i;
                op.value  = directed_plan[r].value ^ i;
                issue_op(op, directed_plan[r].typed, directed_plan[r].reply);
            end
        end

        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (n == 0 || n == RANDOM_OPS / 2)
                long_hold_pending = 1'b1;
            calm_tail = (n >= RANDOM_OPS - CALM_OPS);
            filling   = ((n / 40) % 2 == 0);
            pick      = $urandom_range(0, 99);
            if (pick < (filling ? 70 : 25))
                op.action = ACT_ENQUEUE;
            else if (pick < (filling ? 85 : 80))
                op.action = ACT_DEQUEUE;
            else if (pick < (filling ? 97 : 95))
                op.action = ACT_PEEK;
            else
                op.action = ACT_UNUSED;
            if ($urandom_range(0, 9) < 6)
                op.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                op.key = $urandom;
            op.value = $urandom;
            issue_op(op, 1'b0, no_reply);
        end
        req_bus.valid <= 1'b0;

        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
